// ===== rtl/iidc_pkg.sv =====
package iidc_pkg;

    typedef enum logic [2:0] {
        CMD_I2D   = 3'd0,
        CMD_UI2D  = 3'd1,
        CMD_D2IZ  = 3'd2,
        CMD_D2UIZ = 3'd3,
        CMD_F2D   = 3'd4,
        CMD_D2F   = 3'd5,
        CMD_RSV6  = 3'd6,
        CMD_RSV7  = 3'd7
    } cmd_t;

    localparam logic [10:0] DEXP_MAX  = 11'h7FF;
    localparam logic [10:0] DEXP_BIAS = 11'd1023;
    localparam logic [7:0]  FEXP_MAX  = 8'hFF;
    localparam logic [31:0] I32_MAX   = 32'h7FFFFFFF;
    localparam logic [31:0] I32_MIN   = 32'h80000000;
    localparam logic [31:0] U32_MAX   = 32'hFFFFFFFF;
    localparam logic [31:0] F_INF     = 32'h7F800000;

    // Position of the most significant set bit of a 32-bit word (0 for zero).
    function automatic logic [4:0] msb32(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/ieee_int_float_double_convert_top.sv =====
// Stateless IEEE 754 conversion unit: int32/uint32 to double, double to
// int32/uint32 (truncating, saturating), single to double, and double to
// single with round to nearest even. A transaction is accepted on any cycle
// where start is high; busy is always low because the unit is a three-stage
// pipeline that takes one new command every clock. The result appears on
// result with done high after the decode, alignment and pack stages and is shown for
// a single cycle; the receiver cannot stall the unit, so results must be taken
// when done is high. Stage one decodes the operand and finds the leading-one
// position, stage two performs the wide alignment shift, stage three rounds
// and packs the result word.
module ieee_int_float_double_convert_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [63:0] operand,
    output logic        done,
    output logic [63:0] result
);
    import iidc_pkg::*;

    // Stage one registers.
    logic        v1_reg;
    cmd_t        cmd1_reg;
    logic [63:0] op1_reg;
    logic [4:0]  p1_reg;
    logic        s1_reg;
    logic [31:0] mag1_reg;

    // Stage two registers.
    logic        v2_reg;
    cmd_t        cmd2_reg;
    logic [63:0] op2_reg;
    logic [63:0] sh2_reg;   // shifted value used by the final stage
    logic        stk2_reg;  // bits shifted out, for rounding
    logic        rb2_reg;   // round bit
    logic        zero2_reg; // everything below half an ulp
    logic [31:0] mag2_reg;
    logic [4:0]  p2_reg;
    logic        s2_reg;

    logic        v3_reg;
    logic [63:0] res3_reg;

    assign busy   = 1'b0;
    assign done   = v3_reg;
    assign result = res3_reg;

    // ---------------- stage one: decode ----------------
    logic [31:0] lo;
    logic [31:0] mag_next;
    logic        s_next;
    logic [4:0]  p_next;
    always_comb
    begin
        lo = operand[31:0];
        s_next = 1'b0;
        mag_next = lo;
        unique case (cmd_t'(cmd))
            CMD_I2D:
            begin
                s_next = lo[31];
                mag_next = lo[31] ? (32'd0 - lo) : lo;
            end
            CMD_F2D:  mag_next = {9'd0, lo[22:0]};
            default:  mag_next = lo;
        endcase
        p_next = msb32(mag_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg <= cmd_t'(cmd);
        op1_reg  <= operand;
        p1_reg   <= p_next;
        s1_reg   <= s_next;
        mag1_reg <= mag_next;
    end

    // ---------------- stage two: alignment ----------------
    logic [10:0] e1;
    logic [52:0] sig1;
    logic [63:0] sig1x;
    logic signed [12:0] fe1;
    logic [6:0]  shamt;
    logic [63:0] sh_next;
    logic        stk_next;
    logic        rb_next;
    logic        zero_next;
    logic [52:0] lowmask;
    always_comb
    begin
        e1 = op1_reg[62:52];
        sig1 = (e1 != 11'd0) ? {1'b1, op1_reg[51:0]} : {1'b0, op1_reg[51:0]};
        // The round bit can sit above the significand when the shift is large.
        sig1x = {11'd0, sig1};
        sh_next = 64'd0;
        stk_next = 1'b0;
        rb_next = 1'b0;
        zero_next = 1'b0;
        shamt = 7'd0;
        fe1 = 13'sd0;
        lowmask = 53'd0;
        unique case (cmd1_reg)
            CMD_I2D, CMD_UI2D, CMD_F2D:
            begin
                sh_next = {32'd0, mag1_reg} << (7'd52 - {2'd0, p1_reg});
            end
            CMD_D2IZ, CMD_D2UIZ:
            begin
                // shift right by 52-(e-1023) when 0 <= e-1023 < 32
                shamt = 7'(11'd52 - (e1 - DEXP_BIAS));
                sh_next = {11'd0, sig1} >> shamt;
            end
            CMD_D2F:
            begin
                fe1 = $signed({2'b0, ((e1 == 11'd0) ? 11'd1 : e1)}) - 13'sd896;
                if (fe1 >= 13'sd1)
                begin
                    shamt = 7'd29;
                end
                else if (fe1 < -13'sd33)
                begin
                    shamt = 7'd64;
                end
                else
                begin
                    shamt = 7'(13'sd30 - fe1);
                end
                if (shamt > 7'd63)
                begin
                    zero_next = 1'b1;
                end
                else
                begin
                    sh_next = {11'd0, sig1} >> shamt;
                    lowmask = (53'd1 << (shamt - 7'd1)) - 53'd1;
                    rb_next = sig1x[6'(shamt - 7'd1)];
                    stk_next = |(sig1 & lowmask);
                end
            end
            default: sh_next = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd2_reg  <= cmd1_reg;
        op2_reg   <= op1_reg;
        sh2_reg   <= sh_next;
        stk2_reg  <= stk_next;
        rb2_reg   <= rb_next;
        zero2_reg <= zero_next;
        mag2_reg  <= mag1_reg;
        p2_reg    <= p1_reg;
        s2_reg    <= s1_reg;
    end

    // ---------------- stage three: round and pack ----------------
    logic [10:0] e2;
    logic [51:0] m2;
    logic        sg;
    logic [63:0] res_next;
    logic [31:0] r32;
    logic [31:0] q;
    logic [31:0] val;
    logic signed [12:0] fe2;
    logic [22:0] pl;
    logic [7:0]  fe8;
    always_comb
    begin
        e2 = op2_reg[62:52];
        m2 = op2_reg[51:0];
        sg = op2_reg[63];
        res_next = 64'd0;
        r32 = sh2_reg[31:0];
        q = 32'd0;
        val = 32'd0;
        pl = 23'd0;
        fe8 = 8'd0;
        fe2 = $signed({2'b0, ((e2 == 11'd0) ? 11'd1 : e2)}) - 13'sd896;
        unique case (cmd2_reg)
            CMD_I2D, CMD_UI2D:
            begin
                if (mag2_reg != 32'd0)
                begin
                    res_next = {s2_reg, 11'(DEXP_BIAS + {6'd0, p2_reg}), sh2_reg[51:0]};
                end
                else
                begin
                    res_next = 64'd0;
                end
            end
            CMD_D2IZ:
            begin
                if (e2 == DEXP_MAX || e2 < DEXP_BIAS)
                begin
                    res_next = 64'd0;
                end
                else if (e2 - DEXP_BIAS >= 11'd31)
                begin
                    res_next = {32'd0, sg ? I32_MIN : I32_MAX};
                end
                else
                begin
                    res_next = {32'd0, sg ? (32'd0 - r32) : r32};
                end
            end
            CMD_D2UIZ:
            begin
                if (sg || e2 == DEXP_MAX || e2 < DEXP_BIAS)
                begin
                    res_next = 64'd0;
                end
                else if (e2 - DEXP_BIAS >= 11'd32)
                begin
                    res_next = {32'd0, U32_MAX};
                end
                else
                begin
                    res_next = {32'd0, r32};
                end
            end
            CMD_F2D:
            begin
                fe8 = op2_reg[30:23];
                if (fe8 == FEXP_MAX)
                begin
                    res_next = {op2_reg[31], DEXP_MAX, op2_reg[22:0], 29'd0};
                end
                else if (fe8 == 8'd0)
                begin
                    if (mag2_reg == 32'd0)
                    begin
                        res_next = {op2_reg[31], 63'd0};
                    end
                    else
                    begin
                        res_next = {op2_reg[31], 11'(11'd874 + {6'd0, p2_reg}),
                                    sh2_reg[51:0]};
                    end
                end
                else
                begin
                    res_next = {op2_reg[31], 11'({3'd0, fe8} + 11'd896), op2_reg[22:0],
                                29'd0};
                end
            end
            CMD_D2F:
            begin
                if (e2 == DEXP_MAX)
                begin
                    pl = m2[51:29];
                    if (m2 != 52'd0 && pl == 23'd0)
                    begin
                        pl = 23'h400000;
                    end
                    val = F_INF | {9'd0, pl};
                end
                else if (e2 == 11'd0 && m2 == 52'd0)
                begin
                    val = 32'd0;
                end
                else if (fe2 >= 13'sd255)
                begin
                    val = F_INF;
                end
                else
                begin
                    q = zero2_reg ? 32'd0 : sh2_reg[31:0];
                    if (!zero2_reg && rb2_reg && (stk2_reg || q[0]))
                    begin
                        q = q + 32'd1;
                    end
                    if (fe2 >= 13'sd1)
                    begin
                        val = {1'b0, 8'(fe2 - 13'sd1), 23'd0} + q;
                    end
                    else
                    begin
                        val = q;
                    end
                    if (val >= F_INF)
                    begin
                        val = F_INF;
                    end
                end
                res_next = {32'd0, sg, val[30:0]};
            end
            default: res_next = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res3_reg <= res_next;
    end

    // An accepted transaction reaches done through v1_reg, v2_reg and v3_reg in turn.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done)
        else $error("result strobe missing three cycles after start");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v2_reg) && $past(start, 3))
        else $error("result strobe without a transaction");
    a_int_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && (cmd2_reg == CMD_D2IZ || cmd2_reg == CMD_D2UIZ ||
                    cmd2_reg == CMD_D2F)) |=> (result[63:32] == 32'd0))
        else $error("32-bit result not zero-extended");
endmodule

// ===== tb/sv/ieee_int_float_double_convert_checker.sv =====
module ieee_int_float_double_convert_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  cmd,
    input  logic [63:0] operand,
    input  logic        done,
    input  logic [63:0] result,
    output int          fail_count,
    output int          pending_count,
    output int          convert_count
);
    import iidc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] expected_words[$];

    // Index of the highest set bit; zero for a zero word.
    function automatic int top_bit(input logic [31:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                p = i;
            end
        end
        return p;
    endfunction

    function automatic logic [63:0] mag_to_double(input logic [31:0] mag, input logic sgn);
        int p;
        logic [63:0] m;
        if (mag == 32'd0)
        begin
            return {sgn, 63'd0};
        end
        p = top_bit(mag);
        m = {32'd0, mag} << (52 - p);
        return {sgn, 11'(1023 + p), m[51:0]};
    endfunction

    function automatic logic [31:0] to_int32(input logic [63:0] b);
        int e;
        logic [63:0] m;
        logic [31:0] r;
        e = int'(b[62:52]);
        m = {11'd0, 1'b1, b[51:0]};
        if (e == 2047 || e < 1023)
        begin
            return 32'd0;
        end
        if (e - 1023 >= 31)
        begin
            return b[63] ? I32_MIN : I32_MAX;
        end
        r = 32'(m >> (52 - (e - 1023)));
        return b[63] ? 32'(-r) : r;
    endfunction

    function automatic logic [31:0] to_uint32(input logic [63:0] b);
        int e;
        logic [63:0] m;
        e = int'(b[62:52]);
        m = {11'd0, 1'b1, b[51:0]};
        if (b[63] || e == 2047 || e < 1023)
        begin
            return 32'd0;
        end
        if (e - 1023 >= 32)
        begin
            return U32_MAX;
        end
        return 32'(m >> (52 - (e - 1023)));
    endfunction

    function automatic logic [63:0] widen_single(input logic [31:0] f);
        int e;
        int p;
        logic [63:0] m;
        e = int'(f[30:23]);
        if (e == 255)
        begin
            return {f[31], 11'h7FF, f[22:0], 29'd0};
        end
        if (e == 0)
        begin
            if (f[22:0] == 23'd0)
            begin
                return {f[31], 63'd0};
            end
            p = top_bit({9'd0, f[22:0]});
            m = {41'd0, f[22:0]} << (52 - p);
            return {f[31], 11'(874 + p), m[51:0]};
        end
        return {f[31], 11'(e + 896), f[22:0], 29'd0};
    endfunction

    function automatic logic [31:0] narrow_double(input logic [63:0] b);
        int e;
        int fe;
        int sh;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [22:0] pl;
        logic [31:0] val;
        e = int'(b[62:52]);
        if (e == 2047)
        begin
            pl = b[51:29];
            if (b[51:0] != 52'd0 && pl == 23'd0)
            begin
                pl = 23'h400000;
            end
            return {b[63], 8'hFF, pl};
        end
        if (b[62:0] == 63'd0)
        begin
            return {b[63], 31'd0};
        end
        if (e != 0)
        begin
            sig = {11'd0, 1'b1, b[51:0]};
        end
        else
        begin
            sig = {12'd0, b[51:0]};
            e = 1;
        end
        fe = e - 1023 + 127;
        if (fe >= 255)
        begin
            return {b[63], F_INF[30:0]};
        end
        sh = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 63)
        begin
            q = 64'd0;
        end
        else
        begin
            q = sig >> sh;
            rem = sig & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
            begin
                q = q + 64'd1;
            end
        end
        if (fe >= 1)
        begin
            val = (32'(fe - 1) << 23) + 32'(q);
        end
        else
        begin
            val = 32'(q);
        end
        if (val >= F_INF)
        begin
            val = F_INF;
        end
        return {b[63], val[30:0]};
    endfunction

    function automatic logic [63:0] convert_word(input cmd_t c, input logic [63:0] op);
        case (c)
            CMD_I2D:   return op[31] ? mag_to_double(32'(-op[31:0]), 1'b1)
                                     : mag_to_double(op[31:0], 1'b0);
            CMD_UI2D:  return mag_to_double(op[31:0], 1'b0);
            CMD_D2IZ:  return {32'd0, to_int32(op)};
            CMD_D2UIZ: return {32'd0, to_uint32(op)};
            CMD_F2D:   return widen_single(op[31:0]);
            CMD_D2F:   return {32'd0, narrow_double(op)};
            default:   return 64'd0;
        endcase
    endfunction

    assign pending_count = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            convert_count <= 0;
        end
        else
        begin
            // The result is checked before this edge's new transaction is queued.
            if (done)
            begin
                convert_count <= convert_count + 1;
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected result %h", result);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (result !== expected_words[0])
                    begin
                        if (fail_count < 10)
                        begin
                            $display("result mismatch: expected %h actual %h",
                                     expected_words[0], result);
                        end
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_words.pop_front());
                end
            end
            if (start && !busy)
            begin
                expected_words.push_back(convert_word(cmd_t'(cmd), operand));
            end
        end
    end
endmodule

// ===== tb/sv/ieee_int_float_double_convert_top_test.sv =====
module ieee_int_float_double_convert_top_test;
    import iidc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [63:0] operand;
    logic        done;
    logic [63:0] result;
    int          fail_count;
    int          pending_count;
    int          convert_count;
    longint      cycle_count = 0;

    ieee_int_float_double_convert_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .operand(operand), .done(done), .result(result)
    );

    ieee_int_float_double_convert_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .operand(operand), .done(done), .result(result),
        .fail_count(fail_count), .pending_count(pending_count),
        .convert_count(convert_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // The watchdog allows far more than the slowest correct run, even with
    // heavy sender gaps.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("timeout waiting for results");
            $display("TB_ERROR");
            $finish;
        end
    end

    // Presents one transaction and holds it until the unit accepts it. Start
    // stays high between back-to-back transactions, so it is never dropped
    // and raised in the same time step.
    task automatic issue(input cmd_t c, input logic [63:0] op, input int gap_pct);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        operand <= op;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Builds a double with a chosen unbiased exponent and random fraction.
    function automatic logic [63:0] double_near(input int unb);
        return {1'($urandom), 11'(unb + 1023), $urandom, 20'($urandom)};
    endfunction

    // Random operands weighted toward the boundaries of each conversion.
    function automatic logic [63:0] pick_operand(input cmd_t c);
        logic [63:0] raw;
        int kind;
        raw = {$urandom, $urandom};
        kind = $urandom_range(9);
        case (c)
            CMD_I2D, CMD_UI2D:
                // Short magnitudes exercise the normalizing shift.
                if (kind < 4)
                begin
                    raw[31:0] = raw[31:0] >> $urandom_range(31);
                end
            CMD_D2IZ, CMD_D2UIZ:
                if (kind < 6)
                begin
                    raw = double_near($urandom_range(34) - 2);
                end
                else if (kind == 6)
                begin
                    raw[62:52] = $urandom_range(1) ? 11'h7FF : 11'd0;
                end
            CMD_F2D:
                if (kind < 3)
                begin
                    raw[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
                    raw[22:0] = raw[22:0] >> $urandom_range(22);
                end
            CMD_D2F:
                if (kind < 4)
                begin
                    // Exponents around the single range, including the
                    // subnormal band and the overflow edge.
                    raw = double_near($urandom_range(280) - 152);
                end
                else if (kind < 6)
                begin
                    // Exact ties and near-ties in the rounding bits.
                    raw = double_near($urandom_range(254) - 126);
                    raw[28:0] = {$urandom_range(1) ? 1'b1 : 1'b0, 28'd0}
                                | 29'($urandom_range(1));
                end
                else if (kind == 6)
                begin
                    raw[62:52] = $urandom_range(1) ? 11'h7FF : 11'd0;
                end
            default:
                ;
        endcase
        return raw;
    endfunction

    initial
    begin
        cmd_t c;
        int gap_pct;
        start = 1'b0;
        cmd = CMD_I2D;
        operand = 64'd0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: integer extremes, saturation, special values,
        // single subnormals and NaNs, and double-to-single rounding edges.
        issue(CMD_I2D, 64'h00000000_00000000, 0);
        issue(CMD_I2D, 64'hFFFFFFFF_80000000, 0);
        issue(CMD_I2D, 64'h00000000_7FFFFFFF, 0);
        issue(CMD_UI2D, 64'hFFFFFFFF_FFFFFFFF, 0);
        issue(CMD_UI2D, 64'h00000000_00000001, 0);
        issue(CMD_D2IZ, 64'h41E00000_00000000, 0);
        issue(CMD_D2IZ, 64'hC1E00000_00000000, 0);
        issue(CMD_D2IZ, 64'h7FF80000_00000000, 0);
        issue(CMD_D2IZ, 64'h3FEFFFFF_FFFFFFFF, 0);
        issue(CMD_D2IZ, 64'hC1DFFFFF_FFC00000, 0);
        issue(CMD_D2UIZ, 64'h80000000_00000000, 0);
        issue(CMD_D2UIZ, 64'h41F00000_00000000, 0);
        issue(CMD_D2UIZ, 64'h41EFFFFF_FFE00000, 0);
        issue(CMD_D2UIZ, 64'h000FFFFF_FFFFFFFF, 0);
        issue(CMD_F2D, 64'hFFFFFFFF_00000001, 0);
        issue(CMD_F2D, 64'h00000000_FFC00001, 0);
        issue(CMD_F2D, 64'h00000000_7F800000, 0);
        issue(CMD_D2F, 64'h7FF00000_00000001, 0);
        issue(CMD_D2F, 64'hFFFFFFFF_FFFFFFFF, 0);
        issue(CMD_D2F, 64'h47EFFFFF_F0000000, 0);
        issue(CMD_D2F, 64'h36A00000_00000000, 0);
        issue(CMD_D2F, 64'h800FFFFF_FFFFFFFF, 0);
        issue(CMD_D2F, 64'h3FF00000_30000000, 0);
        issue(CMD_RSV6, 64'hFFFFFFFF_FFFFFFFF, 0);
        issue(CMD_RSV7, 64'h12345678_9ABCDEF0, 0);

        // Random phases: the sender idles rarely, then often, then never.
        for (int n = 0; n < 450; n++)
        begin
            gap_pct = (n < 150) ? 25 : (n < 300) ? 75 : 0;
            c = cmd_t'($urandom_range(99) < 4 ? 6 + $urandom_range(1)
                                              : $urandom_range(5));
            issue(c, pick_operand(c), gap_pct);
        end
        start <= 1'b0;

        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        // The extra wait below catches any stray result from the pipeline.
        repeat (10) @(posedge clk);

        $display("Checked %0d conversions over all six commands and the reserved codes,",
                 convert_count);
        $display("with directed IEEE corner cases and three sender idle phases.");
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
